// ===== rtl/core/cra_pkg.sv =====
package cra_pkg;

    // Operation codes
    typedef enum logic [5:0] {
        OP_NOP   = 6'd0,
        OP_ADC   = 6'd1,
        OP_SBC   = 6'd2,
        OP_AND   = 6'd3,
        OP_ORA   = 6'd4,
        OP_EOR   = 6'd5,
        OP_CMP   = 6'd6,
        OP_CPX   = 6'd7,
        OP_CPY   = 6'd8,
        OP_BIT   = 6'd9,
        OP_LDA   = 6'd10,
        OP_LDX   = 6'd11,
        OP_LDY   = 6'd12,
        OP_ASL_A = 6'd13,
        OP_LSR_A = 6'd14,
        OP_ROL_A = 6'd15,
        OP_ROR_A = 6'd16,
        OP_ASL_M = 6'd17,
        OP_LSR_M = 6'd18,
        OP_ROL_M = 6'd19,
        OP_ROR_M = 6'd20,
        OP_INC   = 6'd21,
        OP_DEC   = 6'd22,
        OP_INX   = 6'd23,
        OP_INY   = 6'd24,
        OP_DEX   = 6'd25,
        OP_DEY   = 6'd26,
        OP_TAX   = 6'd27,
        OP_TAY   = 6'd28,
        OP_TXA   = 6'd29,
        OP_TYA   = 6'd30,
        OP_TSX   = 6'd31,
        OP_TXS   = 6'd32,
        OP_CLC   = 6'd33,
        OP_SEC   = 6'd34,
        OP_CLI   = 6'd35,
        OP_SEI   = 6'd36,
        OP_CLD   = 6'd37,
        OP_SED   = 6'd38,
        OP_CLV   = 6'd39,
        OP_STA   = 6'd40,
        OP_STX   = 6'd41,
        OP_STY   = 6'd42,
        OP_PHA   = 6'd43,
        OP_PHP   = 6'd44,
        OP_PLA   = 6'd45,
        OP_PLP   = 6'd46,
        OP_BPL   = 6'd47,
        OP_BMI   = 6'd48,
        OP_BVC   = 6'd49,
        OP_BVS   = 6'd50,
        OP_BCC   = 6'd51,
        OP_BCS   = 6'd52,
        OP_BNE   = 6'd53,
        OP_BEQ   = 6'd54
    } op_t;

    // Processor flags kept by the unit
    typedef struct packed {
        logic n;
        logic v;
        logic d;
        logic i;
        logic z;
        logic c;
    } flags_t;

    // Architectural register file
    typedef struct packed {
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] sp;
        flags_t     flags;
    } regs_t;

    localparam logic [7:0] SP_RESET = 8'hFD;

    localparam flags_t FLAGS_RESET = '{n: 1'b0, v: 1'b0, d: 1'b0, i: 1'b1,
                                       z: 1'b0, c: 1'b0};

    localparam regs_t REGS_RESET = '{a: 8'h00, x: 8'h00, y: 8'h00,
                                     sp: SP_RESET, flags: FLAGS_RESET};

    // Status byte: N V 1 B D I Z C, with B forced as given
    function automatic logic [7:0] pack_status(input flags_t f, input logic b);
        pack_status = {f.n, f.v, 1'b1, b, f.d, f.i, f.z, f.c};
    endfunction

endpackage

// ===== rtl/core/cpu_register_alu_execute.sv =====
// 8-bit processor execute unit: A, X, Y, SP and flags with the ALU.
//
// Input channel: in_valid / in_stall carry one operation (op) and its
// operand byte. A transfer happens on a rising edge with in_valid high
// and in_stall low. Output channel: out_valid / out_stall carry result,
// status (N V 1 B D I Z C, B reads 0) and take_branch, one per input.
//
// Path: the operation is captured in an input register at the transfer and
// executed against the register file once the result register is free; the
// register file and result register load together when it executes.
// Throughput: one operation per cycle while out_stall is low; the register
// file update is combinational adders, decimal adjust and muxes, so each
// operation sees the state left by the one before it.
//
// Reset: A, X, Y clear, SP is 0xFD, only the interrupt-disable flag is set,
// both pipeline stages empty.
// Stall: while out_stall holds a pending result, one more operation waits in
// the input register; in_stall rises only when both stages are full.
module cpu_register_alu_execute
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [5:0] op,
    input  logic [7:0] operand,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] result,
    output logic [7:0] status,
    output logic       take_branch
);

    // Input register
    logic               in_valid_reg;
    cra_pkg::op_t       op_reg;
    logic [7:0]         operand_reg;

    // Register file and result register
    cra_pkg::regs_t     regs_reg;
    cra_pkg::regs_t     regs_next;
    logic               out_valid_reg;
    logic [7:0]         result_reg;
    logic [7:0]         status_reg;
    logic               branch_reg;

    logic [7:0]         result_next;
    logic [7:0]         status_next;
    logic               branch_next;

    logic               out_free;
    logic               exec_fire;
    logic               in_xfer;

    assign out_free  = !out_valid_reg || !out_stall;
    assign exec_fire = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign in_xfer   = in_valid && !in_stall;

    cra_alu u_alu
    (
        .op          (op_reg),
        .operand     (operand_reg),
        .regs        (regs_reg),
        .regs_next   (regs_next),
        .result      (result_next),
        .status      (status_next),
        .take_branch (branch_next)
    );

    // Input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (exec_fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // Input stage payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg      <= cra_pkg::op_t'(op);
            operand_reg <= operand;
        end
    end

    // Register file commits as the result is loaded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg      <= cra_pkg::REGS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (exec_fire)
            begin
                regs_reg <= regs_next;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            result_reg <= result_next;
            status_reg <= status_next;
            branch_reg <= branch_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result      = result_reg;
    assign status      = status_reg;
    assign take_branch = branch_reg;

    // Register file only moves when an operation executes
    assert property (@(posedge clk) disable iff (!rst_n)
        !exec_fire |=> $stable(regs_reg))
        else $error("register file changed without an executing operation");

    // Input side stalls only when both stages hold work
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled with a free stage");

    // Branch tests produce no data byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && take_branch) |-> (result == 8'h00))
        else $error("taken branch carries a nonzero result");

    // Delivered status has bit 5 set and break clear
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status[5] && !status[4]))
        else $error("status fixed bits wrong");

endmodule

// ===== rtl/core/cra_alu.sv =====
module cra_alu
(
    input  cra_pkg::op_t  op,
    input  logic [7:0]    operand,
    input  cra_pkg::regs_t regs,
    output cra_pkg::regs_t regs_next,
    output logic [7:0]    result,
    output logic [7:0]    status,
    output logic          take_branch
);

    // Update N and Z from a result byte
    function automatic cra_pkg::flags_t with_nz(input cra_pkg::flags_t f,
                                                input logic [7:0] v);
        cra_pkg::flags_t r;
        r   = f;
        r.z = (v == 8'h00);
        r.n = v[7];
        return r;
    endfunction

    logic [7:0] a;
    logic [7:0] m;
    logic       cin;

    assign a   = regs.a;
    assign m   = operand;
    assign cin = regs.flags.c;

    // Binary add with carry
    logic [8:0] adc_bin;
    logic       adc_v;
    assign adc_bin = {1'b0, a} + {1'b0, m} + {8'd0, cin};
    assign adc_v   = ~(a[7] ^ m[7]) & (a[7] ^ adc_bin[7]);

    // Decimal add: low nibble adjust, then high adjust
    logic [4:0] dadd_lo_raw;
    logic [4:0] dadd_lo;
    logic [8:0] dadd_s;
    logic [9:0] dadd_adj;
    logic       dadd_v;
    assign dadd_lo_raw = {1'b0, a[3:0]} + {1'b0, m[3:0]} + {4'd0, cin};
    assign dadd_lo     = (dadd_lo_raw >= 5'd10) ?
                         {1'b1, 4'(dadd_lo_raw[3:0] + 4'd6)} : dadd_lo_raw;
    assign dadd_s      = {1'b0, a[7:4], 4'd0} + {1'b0, m[7:4], 4'd0} + {4'd0, dadd_lo};
    assign dadd_v      = ~(a[7] ^ m[7]) & (a[7] ^ dadd_s[7]);
    assign dadd_adj    = (dadd_s >= 9'h0A0) ? ({1'b0, dadd_s} + 10'h060)
                                           : {1'b0, dadd_s};

    // Binary subtract with borrow
    logic [8:0] sbc_bin;
    logic       sbc_v;
    assign sbc_bin = {1'b0, a} + {1'b0, ~m} + {8'd0, cin};
    assign sbc_v   = (a[7] ^ m[7]) & (a[7] ^ sbc_bin[7]);

    // Decimal subtract result, signed arithmetic in two's complement
    logic [5:0] dsub_lo_raw;
    logic [3:0] dsub_lo_fix;
    logic [5:0] dsub_lo;
    logic [9:0] dsub_s;
    logic [9:0] dsub_adj;
    assign dsub_lo_raw = {2'b00, a[3:0]} - {2'b00, m[3:0]} + {5'd0, cin} - 6'd1;
    assign dsub_lo_fix = 4'(dsub_lo_raw[3:0] + 4'd10);
    assign dsub_lo     = dsub_lo_raw[5] ? {2'b11, dsub_lo_fix} : dsub_lo_raw;
    assign dsub_s      = {2'b00, a[7:4], 4'd0} - {2'b00, m[7:4], 4'd0}
                         + {{4{dsub_lo[5]}}, dsub_lo};
    assign dsub_adj    = dsub_s[9] ? (dsub_s - 10'h060) : dsub_s;

    // Compare source and difference
    logic [7:0] cmp_reg;
    logic [8:0] cmp_diff;
    always_comb
    begin
        case (op)
            cra_pkg::OP_CPX: cmp_reg = regs.x;
            cra_pkg::OP_CPY: cmp_reg = regs.y;
            default:         cmp_reg = a;
        endcase
    end
    assign cmp_diff = {1'b0, cmp_reg} - {1'b0, m};

    // Shift source: accumulator or memory operand
    logic [7:0] sh_src;
    assign sh_src = (op == cra_pkg::OP_ASL_A || op == cra_pkg::OP_LSR_A ||
                     op == cra_pkg::OP_ROL_A || op == cra_pkg::OP_ROR_A) ? a : m;

    // Main operation decode
    cra_pkg::regs_t  nxt;
    cra_pkg::flags_t f;
    logic [7:0]      res;
    logic            br;

    always_comb
    begin
        nxt = regs;
        f   = regs.flags;
        res = 8'h00;
        br  = 1'b0;
        case (op)
            cra_pkg::OP_ADC:
            begin
                if (!f.d)
                begin
                    res = adc_bin[7:0];
                    f.c = adc_bin[8];
                    f.v = adc_v;
                    f   = with_nz(f, res);
                end
                else
                begin
                    res = dadd_adj[7:0];
                    f.z = (adc_bin[7:0] == 8'h00);
                    f.n = dadd_s[7];
                    f.v = dadd_v;
                    f.c = (dadd_adj >= 10'h100);
                end
                nxt.a = res;
            end
            cra_pkg::OP_SBC:
            begin
                f.c   = sbc_bin[8];
                f.v   = sbc_v;
                f     = with_nz(f, sbc_bin[7:0]);
                res   = regs.flags.d ? dsub_adj[7:0] : sbc_bin[7:0];
                nxt.a = res;
            end
            cra_pkg::OP_AND:
            begin
                res = a & m;  nxt.a = res;  f = with_nz(f, res);
            end
            cra_pkg::OP_ORA:
            begin
                res = a | m;  nxt.a = res;  f = with_nz(f, res);
            end
            cra_pkg::OP_EOR:
            begin
                res = a ^ m;  nxt.a = res;  f = with_nz(f, res);
            end
            cra_pkg::OP_CMP, cra_pkg::OP_CPX, cra_pkg::OP_CPY:
            begin
                res = cmp_diff[7:0];
                f.c = ~cmp_diff[8];
                f   = with_nz(f, res);
            end
            cra_pkg::OP_BIT:
            begin
                res = a & m;
                f.z = (res == 8'h00);
                f.n = m[7];
                f.v = m[6];
            end
            cra_pkg::OP_LDA:
            begin
                res = m;  nxt.a = res;  f = with_nz(f, res);
            end
            cra_pkg::OP_LDX:
            begin
                res = m;  nxt.x = res;  f = with_nz(f, res);
            end
            cra_pkg::OP_LDY:
            begin
                res = m;  nxt.y = res;  f = with_nz(f, res);
            end
            cra_pkg::OP_ASL_A, cra_pkg::OP_ASL_M:
            begin
                res = {sh_src[6:0], 1'b0};  f.c = sh_src[7];  f = with_nz(f, res);
                if (op == cra_pkg::OP_ASL_A) nxt.a = res;
            end
            cra_pkg::OP_LSR_A, cra_pkg::OP_LSR_M:
            begin
                res = {1'b0, sh_src[7:1]};  f.c = sh_src[0];  f = with_nz(f, res);
                if (op == cra_pkg::OP_LSR_A) nxt.a = res;
            end
            cra_pkg::OP_ROL_A, cra_pkg::OP_ROL_M:
            begin
                res = {sh_src[6:0], cin};  f.c = sh_src[7];  f = with_nz(f, res);
                if (op == cra_pkg::OP_ROL_A) nxt.a = res;
            end
            cra_pkg::OP_ROR_A, cra_pkg::OP_ROR_M:
            begin
                res = {cin, sh_src[7:1]};  f.c = sh_src[0];  f = with_nz(f, res);
                if (op == cra_pkg::OP_ROR_A) nxt.a = res;
            end
            cra_pkg::OP_INC:
            begin
                res = m + 8'd1;  f = with_nz(f, res);
            end
            cra_pkg::OP_DEC:
            begin
                res = m - 8'd1;  f = with_nz(f, res);
            end
            cra_pkg::OP_INX:
            begin
                res = regs.x + 8'd1;  nxt.x = res;  f = with_nz(f, res);
            end
            cra_pkg::OP_INY:
            begin
                res = regs.y + 8'd1;  nxt.y = res;  f = with_nz(f, res);
            end
            cra_pkg::OP_DEX:
            begin
                res = regs.x - 8'd1;  nxt.x = res;  f = with_nz(f, res);
            end
            cra_pkg::OP_DEY:
            begin
                res = regs.y - 8'd1;  nxt.y = res;  f = with_nz(f, res);
            end
            cra_pkg::OP_TAX:
            begin
                res = a;  nxt.x = res;  f = with_nz(f, res);
            end
            cra_pkg::OP_TAY:
            begin
                res = a;  nxt.y = res;  f = with_nz(f, res);
            end
            cra_pkg::OP_TXA:
            begin
                res = regs.x;  nxt.a = res;  f = with_nz(f, res);
            end
            cra_pkg::OP_TYA:
            begin
                res = regs.y;  nxt.a = res;  f = with_nz(f, res);
            end
            cra_pkg::OP_TSX:
            begin
                res = regs.sp;  nxt.x = res;  f = with_nz(f, res);
            end
            cra_pkg::OP_TXS:
            begin
                res = regs.x;  nxt.sp = res;
            end
            cra_pkg::OP_CLC: f.c = 1'b0;
            cra_pkg::OP_SEC: f.c = 1'b1;
            cra_pkg::OP_CLI: f.i = 1'b0;
            cra_pkg::OP_SEI: f.i = 1'b1;
            cra_pkg::OP_CLD: f.d = 1'b0;
            cra_pkg::OP_SED: f.d = 1'b1;
            cra_pkg::OP_CLV: f.v = 1'b0;
            cra_pkg::OP_STA: res = a;
            cra_pkg::OP_STX: res = regs.x;
            cra_pkg::OP_STY: res = regs.y;
            cra_pkg::OP_PHA:
            begin
                res    = a;
                nxt.sp = regs.sp - 8'd1;
            end
            cra_pkg::OP_PHP:
            begin
                // pushed copy has the break bit set
                res    = cra_pkg::pack_status(f, 1'b1);
                nxt.sp = regs.sp - 8'd1;
            end
            cra_pkg::OP_PLA:
            begin
                nxt.sp = regs.sp + 8'd1;
                res    = m;
                nxt.a  = res;
                f      = with_nz(f, res);
            end
            cra_pkg::OP_PLP:
            begin
                nxt.sp = regs.sp + 8'd1;
                f      = '{n: m[7], v: m[6], d: m[3], i: m[2], z: m[1], c: m[0]};
            end
            cra_pkg::OP_BPL: br = ~f.n;
            cra_pkg::OP_BMI: br = f.n;
            cra_pkg::OP_BVC: br = ~f.v;
            cra_pkg::OP_BVS: br = f.v;
            cra_pkg::OP_BCC: br = ~f.c;
            cra_pkg::OP_BCS: br = f.c;
            cra_pkg::OP_BNE: br = ~f.z;
            cra_pkg::OP_BEQ: br = f.z;
            default: ;
        endcase
        nxt.flags = f;
    end

    assign regs_next   = nxt;
    assign result      = res;
    assign status      = cra_pkg::pack_status(nxt.flags, 1'b0);
    assign take_branch = br;

endmodule

// ===== bench/cra_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the execute unit, predicts each result from its own
// copy of the register file and compares every output transfer in order.
module cra_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [5:0] op,
    input  logic [7:0] operand,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] result,
    input  logic [7:0] status,
    input  logic       take_branch,
    output int         fail_count,
    output int         backlog,
    output int         checked
);

    typedef struct packed {
        logic [7:0] res;
        logic [7:0] stat;
        logic       br;
    } exec_out_t;

    typedef enum logic [1:0] {SH_ASL, SH_LSR, SH_ROL, SH_ROR} shift_kind_t;

    // Shadow register file and the results it predicts, oldest first
    cra_pkg::regs_t st;
    exec_out_t      predicted_results[$];
    int             err_cnt = 0;

    assign fail_count = err_cnt;

    // N and Z from a byte
    function automatic logic [7:0] nz(input logic [7:0] v);
        st.flags.z = (v == 8'h00);
        st.flags.n = v[7];
        return v;
    endfunction

    // Carry from reg >= m, N and Z from the difference
    function automatic logic [7:0] compare_to(input logic [7:0] reg_v, input logic [7:0] m);
        st.flags.c = (reg_v >= m);
        return nz(reg_v - m);
    endfunction

    // Shifts and rotates through carry
    function automatic logic [7:0] shift_val(input shift_kind_t kind, input logic [7:0] v);
        logic       cin;
        logic [7:0] r;
        cin = st.flags.c;
        case (kind)
            SH_ASL:
            begin
                r = {v[6:0], 1'b0};
                st.flags.c = v[7];
            end
            SH_LSR:
            begin
                r = {1'b0, v[7:1]};
                st.flags.c = v[0];
            end
            SH_ROL:
            begin
                r = {v[6:0], cin};
                st.flags.c = v[7];
            end
            default:
            begin
                r = {cin, v[7:1]};
                st.flags.c = v[0];
            end
        endcase
        return nz(r);
    endfunction

    // One operation against the shadow state
    task automatic execute_op(input logic [5:0] code, input logic [7:0] m,
                              output exec_out_t o);
        int         c;
        int         bin;
        int         lo;
        int         s;
        logic [7:0] r;
        logic [7:0] rb;
        logic       br;
        r  = 8'h00;
        br = 1'b0;
        c  = int'(st.flags.c);
        case (cra_pkg::op_t'(code))
            cra_pkg::OP_ADC:
            begin
                bin = int'(st.a) + int'(m) + c;
                if (!st.flags.d)
                begin
                    r = 8'(bin);
                    st.flags.c = (bin > 255);
                    st.flags.v = ~(st.a[7] ^ m[7]) & (st.a[7] ^ r[7]);
                    r = nz(r);
                end
                else
                begin
                    // decimal: low nibble adjust, N/V before high adjust
                    lo = int'(st.a[3:0]) + int'(m[3:0]) + c;
                    if (lo >= 10)
                        lo = ((lo + 6) & 15) + 16;
                    s = int'(st.a[7:4]) * 16 + int'(m[7:4]) * 16 + lo;
                    st.flags.z = ((bin & 255) == 0);
                    st.flags.n = s[7];
                    st.flags.v = ~(st.a[7] ^ m[7]) & (st.a[7] ^ s[7]);
                    if (s >= 160)
                        s = s + 96;
                    st.flags.c = (s >= 256);
                    r = 8'(s);
                end
                st.a = r;
            end
            cra_pkg::OP_SBC:
            begin
                // flags always from the binary difference
                bin = int'(st.a) + int'(m ^ 8'hFF) + c;
                rb  = 8'(bin);
                st.flags.c = (bin > 255);
                st.flags.v = (st.a[7] ^ m[7]) & (st.a[7] ^ rb[7]);
                r = nz(rb);
                if (st.flags.d)
                begin
                    lo = int'(st.a[3:0]) - int'(m[3:0]) + c - 1;
                    if (lo < 0)
                        lo = ((lo + 26) & 15) - 16;
                    s = int'(st.a[7:4]) * 16 - int'(m[7:4]) * 16 + lo;
                    if (s < 0)
                        s = s - 96;
                    r = 8'(s + 512);
                end
                st.a = r;
            end
            cra_pkg::OP_AND: begin st.a = nz(st.a & m); r = st.a; end
            cra_pkg::OP_ORA: begin st.a = nz(st.a | m); r = st.a; end
            cra_pkg::OP_EOR: begin st.a = nz(st.a ^ m); r = st.a; end
            cra_pkg::OP_CMP: r = compare_to(st.a, m);
            cra_pkg::OP_CPX: r = compare_to(st.x, m);
            cra_pkg::OP_CPY: r = compare_to(st.y, m);
            cra_pkg::OP_BIT:
            begin
                r = st.a & m;
                st.flags.z = (r == 8'h00);
                st.flags.n = m[7];
                st.flags.v = m[6];
            end
            cra_pkg::OP_LDA: begin st.a = nz(m); r = st.a; end
            cra_pkg::OP_LDX: begin st.x = nz(m); r = st.x; end
            cra_pkg::OP_LDY: begin st.y = nz(m); r = st.y; end
            cra_pkg::OP_ASL_A: begin st.a = shift_val(SH_ASL, st.a); r = st.a; end
            cra_pkg::OP_LSR_A: begin st.a = shift_val(SH_LSR, st.a); r = st.a; end
            cra_pkg::OP_ROL_A: begin st.a = shift_val(SH_ROL, st.a); r = st.a; end
            cra_pkg::OP_ROR_A: begin st.a = shift_val(SH_ROR, st.a); r = st.a; end
            cra_pkg::OP_ASL_M: r = shift_val(SH_ASL, m);
            cra_pkg::OP_LSR_M: r = shift_val(SH_LSR, m);
            cra_pkg::OP_ROL_M: r = shift_val(SH_ROL, m);
            cra_pkg::OP_ROR_M: r = shift_val(SH_ROR, m);
            cra_pkg::OP_INC: r = nz(m + 8'd1);
            cra_pkg::OP_DEC: r = nz(m - 8'd1);
            cra_pkg::OP_INX: begin st.x = nz(st.x + 8'd1); r = st.x; end
            cra_pkg::OP_INY: begin st.y = nz(st.y + 8'd1); r = st.y; end
            cra_pkg::OP_DEX: begin st.x = nz(st.x - 8'd1); r = st.x; end
            cra_pkg::OP_DEY: begin st.y = nz(st.y - 8'd1); r = st.y; end
            cra_pkg::OP_TAX: begin st.x = nz(st.a); r = st.x; end
            cra_pkg::OP_TAY: begin st.y = nz(st.a); r = st.y; end
            cra_pkg::OP_TXA: begin st.a = nz(st.x); r = st.a; end
            cra_pkg::OP_TYA: begin st.a = nz(st.y); r = st.a; end
            cra_pkg::OP_TSX: begin st.x = nz(st.sp); r = st.x; end
            cra_pkg::OP_TXS: begin st.sp = st.x; r = st.x; end
            cra_pkg::OP_CLC: st.flags.c = 1'b0;
            cra_pkg::OP_SEC: st.flags.c = 1'b1;
            cra_pkg::OP_CLI: st.flags.i = 1'b0;
            cra_pkg::OP_SEI: st.flags.i = 1'b1;
            cra_pkg::OP_CLD: st.flags.d = 1'b0;
            cra_pkg::OP_SED: st.flags.d = 1'b1;
            cra_pkg::OP_CLV: st.flags.v = 1'b0;
            cra_pkg::OP_STA: r = st.a;
            cra_pkg::OP_STX: r = st.x;
            cra_pkg::OP_STY: r = st.y;
            cra_pkg::OP_PHA:
            begin
                r = st.a;
                st.sp = st.sp - 8'd1;
            end
            cra_pkg::OP_PHP:
            begin
                // pushed copy has bits 5 and 4 set
                r = {st.flags.n, st.flags.v, 1'b1, 1'b1,
                     st.flags.d, st.flags.i, st.flags.z, st.flags.c};
                st.sp = st.sp - 8'd1;
            end
            cra_pkg::OP_PLA:
            begin
                st.sp = st.sp + 8'd1;
                st.a = nz(m);
                r = st.a;
            end
            cra_pkg::OP_PLP:
            begin
                // bits 5 and 4 of the pulled byte are dropped
                st.sp = st.sp + 8'd1;
                st.flags = {m[7:6], m[3:0]};
            end
            cra_pkg::OP_BPL: br = ~st.flags.n;
            cra_pkg::OP_BMI: br = st.flags.n;
            cra_pkg::OP_BVC: br = ~st.flags.v;
            cra_pkg::OP_BVS: br = st.flags.v;
            cra_pkg::OP_BCC: br = ~st.flags.c;
            cra_pkg::OP_BCS: br = st.flags.c;
            cra_pkg::OP_BNE: br = ~st.flags.z;
            cra_pkg::OP_BEQ: br = st.flags.z;
            default: ;  // NOP and unused codes
        endcase
        o.res  = r;
        o.stat = {st.flags.n, st.flags.v, 1'b1, 1'b0,
                  st.flags.d, st.flags.i, st.flags.z, st.flags.c};
        o.br   = br;
    endtask

    // Compare output transfers first, then predict the input transfer
    always @(posedge clk or negedge rst_n)
    begin : monitor
        exec_out_t want;
        exec_out_t got;
        if (!rst_n)
        begin
            st = cra_pkg::REGS_RESET;
            predicted_results.delete();
            backlog <= 0;
            checked <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = {result, status, take_branch};
                if (predicted_results.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("%0t: unexpected transfer: result %h status %h branch %b",
                                 $realtime, result, status, take_branch);
                end
                else
                begin
                    want = predicted_results.pop_front();
                    checked <= checked + 1;
                    if (got != want)
                    begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display({"%0t: mismatch result %h/%h status %h/%h ",
                                      "branch %b/%b (exp/got)"},
                                     $realtime, want.res, got.res, want.stat, got.stat,
                                     want.br, got.br);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                execute_op(op, operand, want);
                predicted_results.push_back(want);
            end
            backlog <= predicted_results.size();
        end
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 60;
    localparam logic [5:0] OP_LAST_UNUSED = 6'd63;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [5:0] op = cra_pkg::OP_NOP;
    logic [7:0] operand = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] result;
    logic [7:0] status;
    logic       take_branch;

    int         fail_count;
    int         backlog;
    int         checked;
    int         sent = 0;
    int         holds_done = 0;
    int         idle_cycles = 0;
    bit         hold_request = 1'b0;
    bit [63:0]  ops_seen = '0;

    cpu_register_alu_execute uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .operand     (operand),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result      (result),
        .status      (status),
        .take_branch (take_branch)
    );

    cra_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .operand     (operand),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result      (result),
        .status      (status),
        .take_branch (take_branch),
        .fail_count  (fail_count),
        .backlog     (backlog),
        .checked     (checked)
    );

    always #4 clk = ~clk;

    // Watchdog: too long without any transfer ends the run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: switches between no stall, random stall and a fixed pattern;
    // on request holds off for a long stretch
    initial
    begin : receiver
        int phase;
        int mode;
        phase = 0;
        mode  = 0;
        forever
        begin
            @(posedge clk);
            phase++;
            if (phase % 48 == 0)
                mode = $urandom_range(0, 2);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end
            else
            begin
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 99) < 40);
                    default: out_stall <= ((phase % 5) < 2);
                endcase
            end
        end
    end

    // Offer one item and hold it until the transfer
    task automatic send(input logic [5:0] code, input logic [7:0] val);
        in_valid <= 1'b1;
        op       <= code;
        operand  <= val;
        do
            @(posedge clk);
        while (in_stall);
        sent++;
        ops_seen[code] = 1'b1;
    endtask

    // Stop offering and wait until every predicted result has come out
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (backlog != 0);
        repeat (4) @(posedge clk);
    endtask

    // Weighted toward arithmetic, flags, stack and branches; operands lean to
    // extremes and valid BCD so decimal mode gets real work
    task automatic pick_random_item(output logic [5:0] code, output logic [7:0] val);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 25)
            code = 6'($urandom_range(cra_pkg::OP_ADC, cra_pkg::OP_BIT));
        else if (sel < 35)
            code = 6'($urandom_range(cra_pkg::OP_CLC, cra_pkg::OP_CLV));
        else if (sel < 45)
            code = 6'($urandom_range(cra_pkg::OP_PHA, cra_pkg::OP_PLP));
        else if (sel < 55)
            code = 6'($urandom_range(cra_pkg::OP_BPL, cra_pkg::OP_BEQ));
        else
            code = 6'($urandom_range(0, 63));
        sel = $urandom_range(0, 99);
        if (sel < 15)
        begin
            case ($urandom_range(0, 5))
                0: val = 8'h00;
                1: val = 8'hFF;
                2: val = 8'h7F;
                3: val = 8'h80;
                4: val = 8'h01;
                default: val = 8'h99;
            endcase
        end
        else if (sel < 45)
            val = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
        else
            val = 8'($urandom_range(0, 255));
    endtask

    // Bursts of random length with random gaps
    task automatic run_random(input int count);
        int         n;
        int         burst;
        logic [5:0] code;
        logic [7:0] val;
        n = 0;
        while (n < count)
        begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && n < count; k++)
            begin
                pick_random_item(code, val);
                send(code, val);
                n++;
            end
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    endtask

    initial
    begin : stimulus
        int         directed;
        logic [5:0] code;
        logic [7:0] val;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: overflow, carry, wraps, BIT, decimal add/sub incl. bad BCD,
        // PHP/PLP masking, SP wrap through TXS, unused code
        send(cra_pkg::OP_LDA, 8'h00);
        send(cra_pkg::OP_CLC, 8'h00);
        send(cra_pkg::OP_LDA, 8'h7F);
        send(cra_pkg::OP_ADC, 8'h01);
        send(cra_pkg::OP_ADC, 8'hFF);
        send(cra_pkg::OP_SBC, 8'h80);
        send(cra_pkg::OP_LDX, 8'hFF);
        send(cra_pkg::OP_INX, 8'h00);
        send(cra_pkg::OP_DEY, 8'h00);
        send(cra_pkg::OP_CPX, 8'h00);
        send(cra_pkg::OP_BIT, 8'hC0);
        send(cra_pkg::OP_BVS, 8'h00);
        send(cra_pkg::OP_SED, 8'h00);
        send(cra_pkg::OP_LDA, 8'h99);
        send(cra_pkg::OP_ADC, 8'h01);
        send(cra_pkg::OP_SBC, 8'h00);
        send(cra_pkg::OP_ADC, 8'hFF);
        send(cra_pkg::OP_SBC, 8'hAF);
        send(cra_pkg::OP_PHP, 8'h00);
        send(cra_pkg::OP_PLP, 8'hFF);
        send(cra_pkg::OP_TXS, 8'h00);
        send(cra_pkg::OP_PHA, 8'h00);
        send(cra_pkg::OP_PLA, 8'h80);
        send(cra_pkg::OP_ROR_M, 8'h01);
        send(OP_LAST_UNUSED, 8'hFF);
        directed = sent;
        drain();

        run_random(220);

        // Long output hold-off while the sender keeps offering
        hold_request = 1'b1;
        for (int k = 0; k < 12; k++)
        begin
            pick_random_item(code, val);
            send(code, val);
        end
        drain();

        run_random(270);
        drain();

        $display("%0d items sent (%0d directed), %0d results checked, %0d of 64 op codes",
                 sent, directed, checked, $countones(ops_seen));
        $display("decimal and binary arithmetic, stack wrap, bursty input, %0d long hold-off(s)",
                 holds_done);
        if (fail_count == 0 && backlog == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
